FILE: sv/text_console_cursor_engine_unit_defines.svh
// Assertion macros shared by the console engine checker.
// No dependencies.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH
// Property checked on every rising clock edge outside reset.
`define TCCE_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("assertion failed");
// Stalled transfer keeps valid high and payload steady.
`define TCCE_HOLD(lbl, clk_s, rst_s, vld, rdy, data) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) \
    vld && !rdy |=> vld && $stable(data)) \
    else $error("stalled transfer dropped or changed");
`endif

FILE: sv/tcce_pkg.sv
// Types and constants for the text console engine.
// No dependencies.
`default_nettype none
package tcce_pkg;
  typedef enum logic [1:0] {
    CMD_PUT = 2'd0, CMD_SET = 2'd1, CMD_CLR = 2'd2, CMD_RD = 2'd3
  } cmd_t;
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
  } in_item_t;
  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       out_of_range;
  } out_item_t;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] ATTR_RST = 8'h07;
  localparam logic       REG_ENABLE = 1'b0;
  localparam logic       REG_ATTR   = 1'b1;
endpackage
`default_nettype wire

FILE: sv/tcce_front.sv
// Front end: accepts commands into a two-entry queue.
// Depends on tcce_pkg.
`default_nettype none
module tcce_front
  import tcce_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          q_valid,
  input  wire logic     q_pop,
  output in_item_t      q_item
);
  in_item_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

FILE: sv/tcce_back.sv
// Back end: cursor logic, screen store, scroll and clear sweeps.
// Depends on tcce_pkg.
`default_nettype none
module tcce_back
  import tcce_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       enable,
  input  wire logic [7:0] attribute,
  input  wire logic       q_valid,
  output logic            q_pop,
  input  wire in_item_t   q_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_item
);
  localparam int CELLS = COLS * ROWS;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(COLS + 1);
  localparam int RW = $clog2(ROWS + 1);
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCR_END = AW'(CELLS - COLS - 1);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001, S_IDLE  = 7'b0000010, S_RDW   = 7'b0000100,
    S_RDRES = 7'b0001000, S_SCR   = 7'b0010000, S_FILL  = 7'b0100000,
    S_OUT   = 7'b1000000
  } st_t;

  st_t           st_r, st_nxt;
  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_r;
  logic [AW-1:0] ptr_r, ptr_nxt, fill_end_r, fill_end_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          oor_r, oor_nxt, isrd_r, isrd_nxt;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [15:0]   wd;
  logic          scr_ph_r, scr_ph_nxt;
  logic [7:0]    fill_attr_r, fill_attr_nxt;

  // put-char next cursor
  logic [CW:0]   pc_col;
  logic [RW:0]   pc_row;
  logic          pc_we;
  logic [CW-1:0] pc_wc;
  logic [RW-1:0] pc_wr;

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
    addr = AW'(r * COLS) + AW'(c);
  endfunction

  always_comb begin
    pc_col = {1'b0, col_r};
    pc_row = {1'b0, row_r};
    pc_we  = 1'b0;
    pc_wc  = col_r;
    pc_wr  = row_r;
    priority if (q_item.ch == CH_LF) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
    end else if (q_item.ch == CH_BS) begin
      if (col_r != '0) begin
        pc_col = pc_col - 1'b1;
        pc_we  = 1'b1;
        pc_wc  = col_r - 1'b1;
      end else if (row_r != '0) begin
        pc_row = pc_row - 1'b1;
        pc_col = (CW + 1)'(COLS - 1);
        pc_we  = 1'b1;
        pc_wc  = CW'(COLS - 1);
        pc_wr  = row_r - 1'b1;
      end
    end else if (q_item.ch == CH_TAB) begin
      pc_col = (pc_col + (CW + 1)'(4)) & ~(CW + 1)'(3);
    end else if (q_item.ch == CH_CR) begin
      pc_col = '0;
    end else if (q_item.ch >= CH_SPACE) begin
      pc_we  = 1'b1;
      pc_col = pc_col + 1'b1;
    end
    if (pc_col >= (CW + 1)'(COLS)) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r; ptr_nxt = ptr_r; fill_end_nxt = fill_end_r;
    col_nxt = col_r; row_nxt = row_r; oor_nxt = oor_r; isrd_nxt = isrd_r;
    scr_ph_nxt = scr_ph_r; fill_attr_nxt = fill_attr_r;
    we = 1'b0; wa = ptr_r; wd = {fill_attr_r, CH_SPACE};
    re = 1'b0; ra = ptr_r + AW'(COLS);
    q_pop = 1'b0;
    unique case (st_r)
      S_INIT: begin
        we = 1'b1; wd = {ATTR_RST, CH_SPACE};
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1; oor_nxt = 1'b0; isrd_nxt = 1'b0;
          st_nxt = S_OUT;
          unique case (cmd_t'(q_item.cmd))
            CMD_PUT: if (enable) begin
              we = pc_we; wa = addr(pc_wc, pc_wr);
              wd = {attribute, (q_item.ch == CH_BS) ? CH_SPACE : q_item.ch};
              col_nxt = pc_col[CW-1:0];
              if (pc_row >= (RW + 1)'(ROWS)) begin
                row_nxt = RW'(ROWS - 1);
                ptr_nxt = '0; scr_ph_nxt = 1'b0;
                fill_attr_nxt = attribute;
                st_nxt = S_SCR;
              end else begin
                row_nxt = pc_row[RW-1:0];
              end
            end
            CMD_SET: begin
              col_nxt = (q_item.col >= 8'(COLS)) ? CW'(COLS - 1) : CW'(q_item.col);
              row_nxt = (q_item.row >= 8'(ROWS)) ? RW'(ROWS - 1) : RW'(q_item.row);
            end
            CMD_CLR: begin
              col_nxt = '0; row_nxt = '0; ptr_nxt = '0;
              fill_end_nxt = LAST; fill_attr_nxt = attribute;
              st_nxt = S_FILL;
            end
            CMD_RD: begin
              isrd_nxt = 1'b1;
              if (q_item.col >= 8'(COLS) || q_item.row >= 8'(ROWS)) begin
                oor_nxt = 1'b1;
              end else begin
                re = 1'b1;
                ra = addr(CW'(q_item.col), RW'(q_item.row));
                st_nxt = S_RDW;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDW: st_nxt = S_OUT;
      S_SCR: begin
        // phase 0 reads cell ptr+COLS, phase 1 writes it to ptr
        scr_ph_nxt = ~scr_ph_r;
        if (!scr_ph_r) begin
          re = 1'b1;
        end else begin
          we = 1'b1; wd = rd_r;
          ptr_nxt = ptr_r + 1'b1;
          if (ptr_r == SCR_END) begin
            fill_end_nxt = LAST; st_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == fill_end_r) st_nxt = S_OUT;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    fill_end_r <= fill_end_nxt; oor_r <= oor_nxt;
    isrd_r <= isrd_nxt; fill_attr_r <= fill_attr_nxt;
    if (!rst_n) begin
      st_r <= S_INIT; ptr_r <= '0; col_r <= '0; row_r <= '0; scr_ph_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ptr_r <= ptr_nxt; col_r <= col_nxt; row_r <= row_nxt;
      scr_ph_r <= scr_ph_nxt;
    end
  end

  assign out_valid = (st_r == S_OUT);
  always_comb begin
    out_item.cursor_col   = 7'(col_r);
    out_item.cursor_row   = 5'(row_r);
    out_item.out_of_range = oor_r;
    out_item.cell_char    = (isrd_r && !oor_r) ? rd_r[7:0] : 8'h00;
    out_item.cell_attr    = (isrd_r && !oor_r) ? rd_r[15:8] : 8'h00;
  end
endmodule
`default_nettype wire

FILE: sv/text_console_cursor_engine_unit.sv
// Text console engine top level: config registers, front queue, back end.
// Depends on tcce_pkg, tcce_front, tcce_back.
//
// Usage:
//  - in_valid/in_ready/in_item carry commands (put char, set cursor, clear,
//    read cell); out_valid/out_ready/out_item return one result per command.
//  - cfg_* is an APB-style port: enable at 0x0, attribute at 0x4.
//  - A two-entry queue lets commands arrive while the back end works.
//  - Set cursor, put char without scroll and off-screen reads go from the idle
//    state straight to the result; an on-screen read waits for the registered memory read.
//  - Scroll: one read and one write for each of the COLS*(ROWS-1) moved cells,
//    then a fill of the bottom row. Clear: a fill of all COLS*ROWS cells.
//  - Reset: a clearing pass over all COLS*ROWS cells (2000 by default) writes
//    blanks with attribute 0x07; the queue fills but nothing executes.
//  - A result is held in the output register while out_ready is low; the
//    back end waits, and the queue takes up to two more commands.
//  - Command flow: the back end takes no new command until the last result is
//    taken, its idle and result states alternating; a scroll or clear holds it.
`default_nettype none
module text_console_cursor_engine_unit
  import tcce_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic       enable_r;
  logic [7:0] attr_r;
  logic       q_valid, q_pop;
  in_item_t   q_item;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      attr_r   <= ATTR_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_ENABLE) enable_r <= cfg_pwdata[0];
      else attr_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_ATTR) cfg_prdata = {24'h0, attr_r};
    else cfg_prdata = {31'h0, enable_r};
  end

  tcce_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_item,
    .q_valid, .q_pop, .q_item
  );

  tcce_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
    .clk, .rst_n, .enable(enable_r), .attribute(attr_r),
    .q_valid, .q_pop, .q_item, .out_valid, .out_ready, .out_item
  );
endmodule
`default_nettype wire

FILE: sv/tcce_checker.sv
// Port-level checker for the console engine, bound to the top level.
// Depends on tcce_pkg and the assertion macro header.
`include "text_console_cursor_engine_unit_defines.svh"
`default_nettype none
module tcce_checker
  import tcce_pkg::*;
#(
  parameter int ROWS = 25
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item,
  input wire logic      cfg_pready
);
  `TCCE_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_item)
  `TCCE_ASSERT(a_oor_clean, clk, rst_n, out_valid && out_item.out_of_range |-> out_item.cell_char == 8'h00 && out_item.cell_attr == 8'h00)
  `TCCE_ASSERT(a_pready, clk, rst_n, cfg_pready)
  `TCCE_ASSERT(a_row_range, clk, rst_n, out_valid |-> int'(out_item.cursor_row) < ROWS)
endmodule
bind text_console_cursor_engine_unit tcce_checker #(.ROWS(ROWS)) u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_item, .cfg_pready
);
`default_nettype wire

FILE: verif/text_console_cursor_engine_unit_checker.sv
// Result checker for the text console engine: watches both channels, predicts
// each result from its own screen copy and compares. Depends on tcce_pkg.
`default_nettype none
module text_console_cursor_engine_unit_checker
  import tcce_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item,
  input wire logic      cfg_psel,
  input wire logic      cfg_penable,
  input wire logic      cfg_pwrite,
  input wire logic [2:0] cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] screen [COLS*ROWS];
  int unsigned cur_x, cur_y;
  logic        en_q;
  logic [7:0]  attr_q;
  out_item_t   expected_q[$];

  assign pending = expected_q.size();

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void scroll_up();
    for (int i = 0; i < COLS*(ROWS-1); i++) screen[i] = screen[i+COLS];
    for (int x = 0; x < COLS; x++) screen[(ROWS-1)*COLS+x] = {attr_q, CH_SPACE};
  endfunction

  function automatic void put_char(input logic [7:0] c);
    if (c == CH_LF) begin
      cur_x = 0;
      cur_y++;
    end else if (c == CH_BS) begin
      if (cur_x > 0) begin
        cur_x--;
        screen[cur_y*COLS+cur_x] = {attr_q, CH_SPACE};
      end else if (cur_y > 0) begin
        cur_y--;
        cur_x = COLS - 1;
        screen[cur_y*COLS+cur_x] = {attr_q, CH_SPACE};
      end
    end else if (c == CH_TAB) begin
      cur_x = (cur_x + 4) & ~32'd3;
    end else if (c == CH_CR) begin
      cur_x = 0;
    end else if (c >= CH_SPACE) begin
      screen[cur_y*COLS+cur_x] = {attr_q, c};
      cur_x++;
    end
    if (cur_x >= COLS) begin
      cur_x = 0;
      cur_y++;
    end
    if (cur_y >= ROWS) begin
      scroll_up();
      cur_y = ROWS - 1;
    end
  endfunction

  function automatic out_item_t console_step(input in_item_t it);
    out_item_t r;
    r = '0;
    case (cmd_t'(it.cmd))
      CMD_PUT: if (en_q) put_char(it.ch);
      CMD_SET: begin
        cur_x = (it.col >= COLS) ? COLS - 1 : it.col;
        cur_y = (it.row >= ROWS) ? ROWS - 1 : it.row;
      end
      CMD_CLR: begin
        for (int i = 0; i < COLS*ROWS; i++) screen[i] = {attr_q, CH_SPACE};
        cur_x = 0;
        cur_y = 0;
      end
      default: begin
        if (it.col >= COLS || it.row >= ROWS) r.out_of_range = 1'b1;
        else {r.cell_attr, r.cell_char} = screen[it.row*COLS+it.col];
      end
    endcase
    r.cursor_col = cur_x[6:0];
    r.cursor_row = cur_y[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < COLS*ROWS; i++) screen[i] = {ATTR_RST, CH_SPACE};
      cur_x = 0;
      cur_y = 0;
      en_q = 1'b0;
      attr_q = ATTR_RST;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == REG_ATTR) attr_q = cfg_pwdata[7:0];
        else en_q = cfg_pwdata[0];
      end
      // result transfer checked before this edge's command is predicted
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_item.cursor_col != want.cursor_col)
            report("cursor_col", out_item.cursor_col, want.cursor_col);
          if (out_item.cursor_row != want.cursor_row)
            report("cursor_row", out_item.cursor_row, want.cursor_row);
          if (out_item.cell_char != want.cell_char)
            report("cell_char", out_item.cell_char, want.cell_char);
          if (out_item.cell_attr != want.cell_attr)
            report("cell_attr", out_item.cell_attr, want.cell_attr);
          if (out_item.out_of_range != want.out_of_range)
            report("out_of_range", out_item.out_of_range, want.out_of_range);
        end
      end
      if (in_valid && in_ready) expected_q.push_back(console_step(in_item));
    end
  end
endmodule
`default_nettype wire

FILE: verif/text_console_cursor_engine_unit_tb.sv
// Stimulus and verdict for the text console engine: bursty command traffic,
// register phases and a stalling receiver. Depends on tcce_pkg and the checker.
`default_nettype none
module text_console_cursor_engine_unit_tb
  import tcce_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fail_count, pending;
  int sent_count = 0, scroll_count = 0;
  bit hold_off = 1'b0;   // receiver long stall request
  bit pressure_done = 1'b0;

  always #5 clk = ~clk;

  text_console_cursor_engine_unit #(.COLS(COLS), .ROWS(ROWS)) dut (.*);

  text_console_cursor_engine_unit_checker #(.COLS(COLS), .ROWS(ROWS)) chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready,
    .out_item, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending);

  // Receiver: random stall pattern with calm stretches; a long hold-off
  // is counted here when the sender asks for it.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        if (hold_off) begin
          out_ready <= 1'b0;
          repeat (300) @(negedge clk);
          hold_off = 1'b0;
          pressure_done = 1'b1;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // One command transfer: valid held until accepted; the next send, a gap
  // or settle decides what the valid line does at the following falling edge.
  task automatic send(input logic [1:0] cmd, input logic [7:0] ch,
                      input logic [7:0] col, input logic [7:0] row);
    in_item <= '{cmd: cmd, ch: ch, col: col, row: row};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  // Now and then a random gap after a command; otherwise commands go back to back.
  task automatic send_gap();
    if ($urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Drain all expected results before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Mostly printable text with line controls; some noise bytes.
  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 8'($urandom_range(8'h20, 8'h7E));
    if (k < 70) return 8'($urandom_range(8'h80, 8'hFF));
    if (k < 76) return CH_LF;
    if (k < 80) return CH_TAB;
    if (k < 84) return CH_BS;
    if (k < 87) return CH_CR;
    return 8'($urandom_range(0, 8'h1F));
  endfunction

  task automatic random_phase(input int count);
    int k;
    logic [7:0] c;
    repeat (count) begin
      k = $urandom_range(0, 99);
      c = pick_char();
      if (k < 70) begin
        if (c == CH_LF) scroll_count++;
        send(CMD_PUT, c, 8'($urandom), 8'($urandom));
      end else if (k < 80) begin
        // near-bottom positions push scrolls often
        if ($urandom_range(0, 1))
          send(CMD_SET, 8'($urandom), 8'($urandom_range(0, COLS+2)),
               8'($urandom_range(ROWS-3, ROWS+1)));
        else send(CMD_SET, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (k < 81) begin
        send(CMD_CLR, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (k < 95) begin
        send(CMD_RD, 8'($urandom), 8'($urandom_range(0, COLS)),
             8'($urandom_range(0, ROWS)));
      end else begin
        send(CMD_RD, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      send_gap();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Disabled: put char does nothing; extremes of the fields.
    send(CMD_PUT, 8'h41, 8'hFF, 8'hFF);
    send(CMD_RD, 8'h00, 8'h00, 8'h00);
    send(CMD_RD, 8'hFF, 8'hFF, 8'hFF);
    settle();
    reg_write(3'h0, 32'h1);
    reg_write(3'h4, 32'hFF);

    // Directed: backspace at top-left, printable extremes, controls, wrap,
    // tab past last column, clamped set cursor, scroll, clear.
    send(CMD_PUT, CH_BS, 8'h00, 8'h00);
    send(CMD_PUT, 8'h20, 8'h00, 8'h00);
    send(CMD_PUT, 8'h7F, 8'h00, 8'h00);
    send(CMD_PUT, 8'hFF, 8'h00, 8'h00);
    send(CMD_PUT, 8'h01, 8'h00, 8'h00);
    send(CMD_PUT, CH_TAB, 8'h00, 8'h00);
    send(CMD_PUT, CH_CR, 8'h00, 8'h00);
    send(CMD_RD, 8'h00, 8'h01, 8'h00);
    send(CMD_SET, 8'h00, 8'hFF, 8'hFF);
    send(CMD_PUT, 8'h5A, 8'h00, 8'h00);
    send(CMD_RD, 8'h00, 8'd79, 8'd24);
    send(CMD_SET, 8'h00, 8'd77, 8'd24);
    send(CMD_PUT, CH_TAB, 8'h00, 8'h00);
    send(CMD_SET, 8'h00, 8'd0, 8'd10);
    send(CMD_PUT, CH_BS, 8'h00, 8'h00);
    send(CMD_RD, 8'h00, 8'd79, 8'd9);
    send(CMD_SET, 8'h00, 8'd3, 8'd24);
    send(CMD_PUT, CH_LF, 8'h00, 8'h00);
    send(CMD_RD, 8'h00, 8'd3, 8'd24);
    send(CMD_RD, 8'h00, 8'd80, 8'd0);
    send(CMD_RD, 8'h00, 8'd0, 8'd25);
    send(CMD_CLR, 8'h00, 8'h00, 8'h00);
    send(CMD_RD, 8'h00, 8'd40, 8'd12);
    settle();

    // Pressure: long receiver hold-off while commands keep coming.
    hold_off = 1'b1;
    random_phase(40);
    settle();

    // Register settings, extremes included, each with random traffic.
    reg_write(3'h4, 32'h00);
    random_phase(450);
    settle();
    reg_write(3'h4, 32'h5A);
    random_phase(450);
    settle();
    reg_write(3'h0, 32'h0);
    reg_write(3'h4, 32'hA5);
    random_phase(150);
    settle();
    reg_write(3'h0, 32'h1);
    reg_write(3'h4, 32'h07);
    random_phase(700);
    settle();

    $display("Covered %0d commands with about %0d newlines, long stall %s.",
             sent_count, scroll_count, pressure_done ? "done" : "missed");
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Run limit: well above the slowest correct run with scrolls and stalls.
  initial begin
    #500ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: text_console_cursor_engine_unit.f
+incdir+sv
sv/tcce_pkg.sv
sv/tcce_front.sv
sv/tcce_back.sv
sv/text_console_cursor_engine_unit.sv
sv/tcce_checker.sv
verif/text_console_cursor_engine_unit_checker.sv
verif/text_console_cursor_engine_unit_tb.sv
